FILE: rtl/clt_pkg.sv
// Shared types and constants of the CIGAR length tally unit.
package clt_pkg;

  localparam int unsigned LenW = 31;
  localparam logic [LenW-1:0] MaxLen = {LenW{1'b1}};

  // Widened product of the digit run: value * 10 + digit
  localparam int unsigned MulW = LenW + 4;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharOpS   = 8'h53;
  localparam logic [7:0] CharOpD   = 8'h44;
  localparam logic [7:0] CharOpI   = 8'h49;
  localparam logic [7:0] CharOpM   = 8'h4D;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_SPACE,
    KIND_OTHER
  } char_kind_e;

  typedef enum logic [2:0] {
    OP_S,
    OP_D,
    OP_I,
    OP_M,
    OP_OTHER
  } op_kind_e;

  // One classified character as it travels through the queue
  typedef struct packed {
    char_kind_e  kind;
    logic [3:0]  digit;
    op_kind_e    op;
    logic        last;
  } item_t;

endpackage

FILE: rtl/clt_in_if.sv
// Input channel: one CIGAR character per item.
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/clt_out_if.sv
// Output channel: the three length sums of one CIGAR string per item.
interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] query_length;
  logic [30:0] reference_length;
  logic [30:0] mismatch_length;
  logic        any_nonzero;

  modport source (output valid, output query_length, output reference_length,
                  output mismatch_length, output any_nonzero, input ready);
  modport sink   (input valid, input query_length, input reference_length,
                  input mismatch_length, input any_nonzero, output ready);
endinterface

FILE: rtl/clt_front.sv
// Front end: classify an incoming character into kind, digit value and operation.
module clt_front (
  input  logic [7:0]    char_code_i,
  input  logic          last_char_i,
  output clt_pkg::item_t item_o
);
  import clt_pkg::*;

  logic [7:0] digit_off;

  assign digit_off = char_code_i - CharZero;

  always_comb begin
    item_o.last  = last_char_i;
    item_o.digit = digit_off[3:0];
    item_o.kind  = KIND_OTHER;
    item_o.op    = OP_OTHER;
    if (char_code_i inside {[CharZero:CharNine]}) begin
      item_o.kind = KIND_DIGIT;
    end else if (char_code_i inside {CharTab, CharLf, CharFf, CharCr, CharSpace}) begin
      item_o.kind = KIND_SPACE;
    end
    case (char_code_i)
      CharOpS: item_o.op = OP_S;
      CharOpD: item_o.op = OP_D;
      CharOpI: item_o.op = OP_I;
      CharOpM: item_o.op = OP_M;
      default: item_o.op = OP_OTHER;
    endcase
  end

endmodule

FILE: rtl/clt_queue.sv
// Two-entry queue of classified characters between front and back.
module clt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clt_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output clt_pkg::item_t head_o,
  output logic           head_valid_o
);
  import clt_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  item_t      mem_q [2];

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/clt_back.sv
// Back end: parse state, length accumulation, saturating sums and result register.
module clt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clt_pkg::item_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  clt_out_if.source      out_o
);
  import clt_pkg::*;

  logic [LenW-1:0] acc_q, acc_d, prev_q, prev_d;
  logic            over_q, over_d, prev_over_q, prev_over_d;
  logic [1:0]      dc_q, dc_d;
  logic            stop_q, stop_d;
  logic [LenW-1:0] qsum_q, qsum_d, rsum_q, rsum_d, msum_q, msum_d;
  logic            out_valid_q;
  logic [LenW-1:0] out_q_q, out_r_q, out_m_q;
  logic            out_nz_q;

  logic            add_en;
  logic [LenW-1:0] add_len;
  op_kind_e        add_op;
  logic [MulW-1:0] mul;
  logic            load;

  function automatic logic [LenW-1:0] sat_add(input logic [LenW-1:0] a,
                                              input logic [LenW-1:0] b);
    logic [LenW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LenW] ? MaxLen : s[LenW-1:0];
  endfunction

  assign pop_o = head_valid_i && (!head_i.last || !out_valid_q || out_o.ready);
  assign load  = pop_o && head_i.last;
  assign mul   = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + MulW'(head_i.digit);

  always_comb begin
    acc_d       = acc_q;
    prev_d      = prev_q;
    over_d      = over_q;
    prev_over_d = prev_over_q;
    dc_d        = dc_q;
    stop_d      = stop_q;
    add_en      = 1'b0;
    add_len     = acc_q;
    add_op      = OP_OTHER;
    if (pop_o && !stop_q) begin
      case (head_i.kind)
        KIND_DIGIT: begin
          if (dc_q == 2'd0) begin
            prev_d      = '0;
            prev_over_d = 1'b0;
            acc_d       = LenW'(head_i.digit);
            over_d      = 1'b0;
          end else begin
            prev_d      = acc_q;
            prev_over_d = over_q;
            if (over_q || (|mul[MulW-1:LenW])) begin
              over_d = 1'b1;
              acc_d  = MaxLen;
            end else begin
              acc_d = mul[LenW-1:0];
            end
          end
          if (dc_q != 2'd2) begin
            dc_d = dc_q + 2'd1;
          end
          // Last digit of a run of two or more acts as the operation
          if (head_i.last) begin
            stop_d = 1'b1;
            if (dc_q != 2'd0 && !over_q) begin
              add_en  = 1'b1;
              add_len = acc_q;
            end
          end
        end
        KIND_SPACE: begin
          stop_d = 1'b1;
          if (dc_q == 2'd2 && !prev_over_q) begin
            add_en  = 1'b1;
            add_len = prev_q;
          end
        end
        default: begin
          if (dc_q == 2'd0 || over_q) begin
            stop_d = 1'b1;
          end else begin
            add_en  = 1'b1;
            add_len = acc_q;
            add_op  = head_i.op;
            dc_d    = 2'd0;
          end
        end
      endcase
    end

    qsum_d = qsum_q;
    rsum_d = rsum_q;
    msum_d = msum_q;
    if (add_en && add_op != OP_S) begin
      if (add_op != OP_D) qsum_d = sat_add(qsum_q, add_len);
      if (add_op != OP_I) rsum_d = sat_add(rsum_q, add_len);
      if (add_op != OP_M) msum_d = sat_add(msum_q, add_len);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      prev_q      <= '0;
      over_q      <= 1'b0;
      prev_over_q <= 1'b0;
      dc_q        <= 2'd0;
      stop_q      <= 1'b0;
      qsum_q      <= '0;
      rsum_q      <= '0;
      msum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        // String done: drop all parse state for the next string
        acc_q       <= '0;
        prev_q      <= '0;
        over_q      <= 1'b0;
        prev_over_q <= 1'b0;
        dc_q        <= 2'd0;
        stop_q      <= 1'b0;
        qsum_q      <= '0;
        rsum_q      <= '0;
        msum_q      <= '0;
      end else begin
        acc_q       <= acc_d;
        prev_q      <= prev_d;
        over_q      <= over_d;
        prev_over_q <= prev_over_d;
        dc_q        <= dc_d;
        stop_q      <= stop_d;
        qsum_q      <= qsum_d;
        rsum_q      <= rsum_d;
        msum_q      <= msum_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q_q  <= qsum_d;
      out_r_q  <= rsum_d;
      out_m_q  <= msum_d;
      out_nz_q <= |(qsum_d | rsum_d | msum_d);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.query_length     = out_q_q;
  assign out_o.reference_length = out_r_q;
  assign out_o.mismatch_length  = out_m_q;
  assign out_o.any_nonzero      = out_nz_q;

  a_dc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q != 2'd3)
    else $error("digit count out of range");

  a_over_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |-> acc_q == MaxLen)
    else $error("oversized run not pinned at max");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (dc_q == 2'd0 && !stop_q && qsum_q == '0 && rsum_q == '0 && msum_q == '0))
    else $error("parse state not cleared after final character");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !load)
    else $error("pending result overwritten");

endmodule

FILE: rtl/cigar_length_tally_unit.sv
// Top level of the CIGAR length tally unit: front classifier, queue, back end.
// Path: an accepted character is written to the queue, and the back end processes it
//   from the queue head; a final character's sums are loaded into the result register.
// Throughput: one character per cycle, set by the back end update (multiply-by-ten
//   add plus three saturating adds); a final character waits while a result is untaken.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_ni low, asynchronous): queue empty, parse state and sums zero, no result.
module cigar_length_tally_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  clt_in_if.sink    in_ch_i,
  clt_out_if.source out_ch_o
);
  import clt_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  head_valid;

  // Classify the character as it arrives
  clt_front u_front (
    .char_code_i (in_ch_i.char_code),
    .last_char_i (in_ch_i.last_char),
    .item_o      (front_item)
  );

  // Accept whenever the queue has room; the back end drains it on its own
  assign in_ch_i.ready = !q_full;
  assign q_push        = in_ch_i.valid && !q_full;

  clt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_item_i  (front_item),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (head_item),
    .head_valid_o (head_valid)
  );

  // Parse, tally and hold the result until the sink takes it
  clt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (head_valid),
    .pop_o        (q_pop),
    .out_o        (out_ch_o)
  );

endmodule
